// File: sv/tuch_pkg.sv
// ----------------------------------------------------------------------------
// tuch_pkg
// Shared types and constants of the tile command handler: command codes,
// answer framing bytes and the structs passed between frame and answer logic.
// ----------------------------------------------------------------------------
package tuch_pkg;

	// command codes (frame byte 0)
	localparam logic [7:0] CMD_ASSIGN = 8'h01;
	localparam logic [7:0] CMD_EDGE   = 8'h02;
	localparam logic [7:0] CMD_REPORT = 8'h03;
	localparam logic [7:0] CMD_COLOUR = 8'h08;
	localparam logic [7:0] CMD_CALL   = 8'h09;

	// framing
	localparam logic [7:0] ANS_HEAD   = 8'h80;
	localparam logic [7:0] ANS_TAIL   = 8'hA0;
	localparam logic [7:0] ADDR_BCAST = 8'hFF;
	localparam logic [7:0] NEWLINE    = 8'h0A;

	// answer frame geometry
	localparam int ANS_N  = 10;
	localparam int ANS_IW = 4;
	localparam logic [ANS_IW-1:0] ANS_LAST   = ANS_IW'(ANS_N - 1);
	localparam logic [ANS_IW-1:0] ECHO_INIT  = ANS_IW'(ANS_N);
	localparam logic [ANS_IW-1:0] SHORT_LAST = ANS_IW'(2);
	localparam logic [ANS_IW-1:0] LONG_LAST  = ANS_IW'(5);

	// config port
	localparam int APB_AW = 3;

	// answer request from the frame decoder
	typedef struct packed {
		logic        valid;
		logic        is_long;
		logic [7:0]  code;
		logic [31:0] id;
	} tuch_req_t;

	// live pin drive and LED state
	typedef struct packed {
		logic [2:0] drive;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} tuch_status_t;

endpackage

// File: sv/tile_uart_command_handler_top.sv
// ----------------------------------------------------------------------------
// tile_uart_command_handler_top
// Tile serial command handler: frames received bytes, decodes commands and
// streams ten-byte answer frames.
// ----------------------------------------------------------------------------
// Usage
//  Input channel (in_valid/in_ready): one received byte per word with the
//   three sensed edge levels. Bytes are taken one per cycle; only a newline
//   that ends a frame waits while an earlier answer is still being built or
//   drained. Echo bytes and ordinary frame bytes are never held off.
//  Output channel (out_valid/out_ready): ten words per answer, last_byte set
//   on the tenth, each carrying the pin drives and LED colour as updated by
//   the command that caused the answer.
//  The answer store is written one byte per cycle (3 or 6 bytes) before it
//   is read back one byte per cycle, so the ten words then follow one per
//   cycle while out_ready holds.
//  Stall: a low out_ready holds the output word; the memory read stage keeps
//   one more word, and reads resume when the output register frees.
//  Reset (arst_n low): frame and answer contents read as zero, addresses and
//   edge mask clear, colour returns to 100/100/100, long_id clears. No
//   clearing pass is needed; the answer store carries a valid bit per byte.
//  Config: APB, long_id at byte address 0; pready is always high.
// ----------------------------------------------------------------------------
module tile_uart_command_handler_top #(
	parameter int FRAME_BYTES = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB config
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tuch_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// received bytes
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  rx_byte,
	input  logic                        edge_a_level,
	input  logic                        edge_b_level,
	input  logic                        edge_c_level,
	// answer words
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  tx_byte,
	output logic                        last_byte,
	output logic                        drive_a,
	output logic                        drive_b,
	output logic                        drive_c,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue
);
	import tuch_pkg::*;

	logic [31:0]  long_id_q;
	logic         cfg_wr;
	logic         ans_busy;
	tuch_req_t    req;
	tuch_status_t status;

	// register index is paddr[2]; only index 0 exists
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[APB_AW-1];
	assign pready = 1'b1;
	assign prdata = paddr[APB_AW-1] ? 32'h0 : long_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_id_q <= '0;
		end else if (cfg_wr) begin
			long_id_q <= pwdata;
		end
	end

	// frame collection, command decode, tile state
	tuch_frame #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.edge_a_level (edge_a_level),
		.edge_b_level (edge_b_level),
		.edge_c_level (edge_c_level),
		.long_id      (long_id_q),
		.ans_busy     (ans_busy),
		.req          (req),
		.status       (status)
	);

	// answer store and output stream
	tuch_answer u_answer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.status    (status),
		.busy      (ans_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.last_byte (last_byte),
		.drive_a   (drive_a),
		.drive_b   (drive_b),
		.drive_c   (drive_c),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// File: sv/tuch_frame.sv
// ----------------------------------------------------------------------------
// tuch_frame
// Collects received bytes into the frame store, skips echo bytes, decodes
// the command on newline and holds short address, edge mask and colour.
// ----------------------------------------------------------------------------
module tuch_frame #(
	parameter int FRAME_BYTES = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	input  logic                  edge_a_level,
	input  logic                  edge_b_level,
	input  logic                  edge_c_level,
	input  logic [31:0]           long_id,
	input  logic                  ans_busy,
	output tuch_pkg::tuch_req_t    req,
	output tuch_pkg::tuch_status_t status
);
	import tuch_pkg::*;

	localparam int IW = $clog2(FRAME_BYTES);
	localparam int PW = $clog2(FRAME_BYTES + 1);
	localparam logic [PW-1:0] POS_MAX = PW'(FRAME_BYTES);

	logic [7:0]        frame_q [FRAME_BYTES];
	logic [7:0]        fn [FRAME_BYTES];
	logic [PW-1:0]     pos_q;
	logic [ANS_IW-1:0] echo_q;
	logic [7:0]        short_q;
	logic [7:0]        mask_q;
	logic [7:0]        red_q, green_q, blue_q;
	tuch_req_t         req_q, req_d;
	logic              accept, in_echo, is_nl, store_ok, addressed, fire;
	logic [7:0]        id0, id1, id2, cmd;

	always_comb begin
		id0 = long_id[31:24];
		id1 = long_id[23:16];
		id2 = long_id[15:8];
		in_echo  = echo_q != '0;
		is_nl    = rx_byte == NEWLINE;
		// a newline may start an answer, so it waits for the answer unit
		in_ready = in_echo || !is_nl || !(ans_busy || req_q.valid);
		accept   = in_valid && in_ready;
		store_ok = pos_q < POS_MAX;
		// frame as it stands after this byte is written
		for (int k = 0; k < FRAME_BYTES; k++) begin
			fn[k] = (store_ok && pos_q[IW-1:0] == IW'(k)) ? rx_byte : frame_q[k];
		end
		cmd       = fn[0];
		addressed = fn[1] == short_q || fn[1] == ADDR_BCAST;
		req_d.valid   = 1'b0;
		req_d.is_long = 1'b0;
		req_d.code    = cmd;
		req_d.id      = long_id;
		case (cmd)
			CMD_ASSIGN: req_d.valid = fn[2] == id0 && fn[3] == id1 && fn[4] == id2;
			CMD_EDGE:   req_d.valid = addressed;
			CMD_REPORT: begin
				req_d.valid   = mask_q == '0 && short_q == '0 &&
					(!edge_a_level || !edge_b_level || !edge_c_level);
				req_d.is_long = 1'b1;
			end
			CMD_COLOUR: req_d.valid = addressed;
			CMD_CALL:   req_d.valid = short_q == '0;
			default:    req_d.valid = 1'b0;
		endcase
		fire = accept && !in_echo && is_nl && req_d.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FRAME_BYTES; k++) frame_q[k] <= '0;
			pos_q   <= '0;
			echo_q  <= '0;
			short_q <= '0;
			mask_q  <= '0;
			red_q   <= 8'd100;
			green_q <= 8'd100;
			blue_q  <= 8'd100;
			req_q   <= '0;
		end else begin
			req_q.valid <= fire;
			if (fire) begin
				req_q.is_long <= req_d.is_long;
				req_q.code    <= req_d.code;
				req_q.id      <= req_d.id;
			end
			if (accept) begin
				if (in_echo) begin
					echo_q <= echo_q - 1'b1;
				end else begin
					if (store_ok) frame_q[pos_q[IW-1:0]] <= rx_byte;
					if (!is_nl) begin
						if (store_ok) pos_q <= pos_q + 1'b1;
					end else begin
						pos_q <= '0;
						if (fire) begin
							echo_q <= ECHO_INIT;
							case (cmd)
								CMD_ASSIGN: short_q <= fn[6];
								CMD_EDGE:   mask_q  <= fn[2];
								CMD_COLOUR: begin
									red_q   <= fn[2];
									green_q <= fn[3];
									blue_q  <= fn[4];
								end
								default: ;
							endcase
						end
					end
				end
			end
		end
	end

	assign req          = req_q;
	assign status.drive = mask_q[2:0];
	assign status.red   = red_q;
	assign status.green = green_q;
	assign status.blue  = blue_q;

	a_fire_req: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> req_q.valid && echo_q == ECHO_INIT)
		else $error("answer request or echo window missing after decode");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_echo && is_nl |=> pos_q == '0)
		else $error("frame position not cleared by newline");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("frame position past end of frame store");

endmodule

// File: sv/tuch_answer.sv
// ----------------------------------------------------------------------------
// tuch_answer
// Answer store in a single-port-write, registered-read memory. Builds the
// requested answer bytes into it, then streams all ten bytes out.
// ----------------------------------------------------------------------------
module tuch_answer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tuch_pkg::tuch_req_t    req,
	input  tuch_pkg::tuch_status_t status,
	output logic                   busy,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             tx_byte,
	output logic                   last_byte,
	output logic                   drive_a,
	output logic                   drive_b,
	output logic                   drive_c,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);
	import tuch_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_BUILD = 2'd1;
	localparam logic [1:0] PH_DRAIN = 2'd2;

	logic [7:0]        mem [ANS_N];
	logic [ANS_N-1:0]  vld_q;
	logic [1:0]        phase_q;
	logic              long_q;
	logic [7:0]        code_q;
	logic [31:0]       id_q;
	logic [ANS_IW-1:0] wr_idx_q, rd_idx_q, wr_last;
	logic [7:0]        wr_data;
	logic              rd_valid_s1, rd_vld_s1, rd_last_s1;
	logic [7:0]        rd_data_s1;
	logic              out_valid_q;
	logic              move, issue, wr_en;

	always_comb begin
		wr_last = long_q ? LONG_LAST : SHORT_LAST;
		case (wr_idx_q)
			ANS_IW'(0): wr_data = ANS_HEAD;
			ANS_IW'(1): wr_data = long_q ? id_q[31:24] : code_q;
			ANS_IW'(2): wr_data = long_q ? id_q[23:16] : ANS_TAIL;
			ANS_IW'(3): wr_data = id_q[15:8];
			ANS_IW'(4): wr_data = id_q[7:0];
			ANS_IW'(5): wr_data = ANS_TAIL;
			default:    wr_data = '0;
		endcase
		wr_en = phase_q == PH_BUILD;
		move  = rd_valid_s1 && (!out_valid_q || out_ready);
		issue = phase_q == PH_DRAIN && (!rd_valid_s1 || move);
		busy  = phase_q != PH_IDLE || rd_valid_s1 || out_valid_q;
	end

	// answer store
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx_q] <= wr_data;
		if (issue) rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			vld_q       <= '0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			long_q      <= 1'b0;
			code_q      <= '0;
			id_q        <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (req.valid) begin
						phase_q  <= PH_BUILD;
						wr_idx_q <= '0;
						long_q   <= req.is_long;
						code_q   <= req.code;
						id_q     <= req.id;
					end
				end
				PH_BUILD: begin
					vld_q[wr_idx_q] <= 1'b1;
					wr_idx_q        <= wr_idx_q + 1'b1;
					if (wr_idx_q == wr_last) begin
						phase_q  <= PH_DRAIN;
						rd_idx_q <= '0;
					end
				end
				PH_DRAIN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (rd_idx_q == ANS_LAST) phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase

			if (issue) begin
				rd_valid_s1 <= 1'b1;
				rd_vld_s1   <= vld_q[rd_idx_q];
				rd_last_s1  <= rd_idx_q == ANS_LAST;
			end else if (move) begin
				rd_valid_s1 <= 1'b0;
			end

			if (move)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (move) begin
			tx_byte   <= rd_vld_s1 ? rd_data_s1 : 8'h00;
			last_byte <= rd_last_s1;
			drive_a   <= status.drive[0];
			drive_b   <= status.drive[1];
			drive_c   <= status.drive[2];
			red       <= status.red;
			green     <= status.green;
			blue      <= status.blue;
		end
	end

	assign out_valid = out_valid_q;

	a_req_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !busy)
		else $error("answer request while answer unit busy");

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> rd_idx_q <= ANS_LAST)
		else $error("answer read past last byte");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ready && last_byte |=> !out_valid_q)
		else $error("word follows directly after last answer byte");

endmodule
